/* hw/rtl/mrbim_pkg.sv */
// Package for the multi-reader buffer index manager.
// Types, codes and sizing constants shared by the controller, datapath and top level.
// No dependencies.
package mrbim_pkg;

    localparam int READER_SLOTS  = 8;
    localparam int SPARE_BUFFERS = 2;
    localparam int NBUF_MAX      = READER_SLOTS + SPARE_BUFFERS;
    localparam int SLOT_W        = $clog2(READER_SLOTS);
    localparam int BUF_W         = 4;
    localparam int CNT_W         = 4;

    localparam logic [2:0] CMD_ACQUIRE = 3'd0;
    localparam logic [2:0] CMD_PUBLISH = 3'd1;
    localparam logic [2:0] CMD_OPEN    = 3'd2;
    localparam logic [2:0] CMD_CLOSE   = 3'd3;
    localparam logic [2:0] CMD_FETCH   = 3'd4;

    localparam logic [1:0] STS_OK         = 2'd0;
    localparam logic [1:0] STS_NO_BUFFER  = 2'd1;
    localparam logic [1:0] STS_NO_PENDING = 2'd2;
    localparam logic [1:0] STS_NO_SLOT    = 2'd3;

    localparam logic [CNT_W-1:0] READERS_RESET = CNT_W'(READER_SLOTS);

    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] reader_id;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] buffer_index;
        logic [2:0] granted_reader;
    } t_out_word;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_ctrl;

endpackage

/* hw/rtl/mrbim_ctrl.sv */
// Controller for the buffer index manager: two-state sequencer.
// Depends on mrbim_pkg.
module mrbim_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    output mrbim_pkg::t_dp_ctrl o_dp_ctrl
);
    import mrbim_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy              = 1'b0;
        o_dp_ctrl.capture = 1'b0;
        o_dp_ctrl.execute = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_dp_ctrl.capture = start;
            end
            ST_EXEC: begin
                busy              = 1'b1;
                o_dp_ctrl.execute = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

/* hw/rtl/mrbim_dp.sv */
// Datapath for the buffer index manager: bookkeeping state, buffer and slot scans,
// result register. Depends on mrbim_pkg.
module mrbim_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mrbim_pkg::t_dp_ctrl             i_dp_ctrl,
    input  mrbim_pkg::t_in_word             i_in,
    input  logic                            i_cfg_we,
    input  logic [mrbim_pkg::CNT_W-1:0]     i_cfg_wdata,
    output logic                            o_strobe,
    output mrbim_pkg::t_out_word            o_out
);
    import mrbim_pkg::*;

    // buffer numbers are kept one-based, zero means none
    logic [CNT_W-1:0]  r_readers;
    logic [BUF_W-1:0]  r_latest, n_latest;
    logic [BUF_W-1:0]  r_pending, n_pending;
    logic [BUF_W-1:0]  r_holds [READER_SLOTS];
    logic [BUF_W-1:0]  n_holds [READER_SLOTS];
    logic [READER_SLOTS-1:0] r_taken, n_taken;
    logic [CNT_W-1:0]  r_open, n_open;
    t_in_word          r_in;
    t_out_word         r_out, n_out;
    logic              r_strobe;

    logic [CNT_W-1:0]  eff_r;
    logic [BUF_W-1:0]  nbuf;
    logic [NBUF_MAX-1:0] buf_free;
    logic              any_buf;
    logic [BUF_W-1:0]  free_buf;
    logic [READER_SLOTS-1:0] slot_free;
    logic              any_slot;
    logic [SLOT_W-1:0] free_slot;

    always_comb begin
        if (r_readers == '0)
            eff_r = CNT_W'(1);
        else if (r_readers > CNT_W'(READER_SLOTS))
            eff_r = CNT_W'(READER_SLOTS);
        else
            eff_r = r_readers;
        nbuf = BUF_W'(eff_r) + BUF_W'(SPARE_BUFFERS);
    end

    // buffer is free when it lies within the live buffer count and is neither latest nor held by an active slot
    always_comb begin
        logic used;
        for (int b = 0; b < NBUF_MAX; b++) begin
            used = (r_latest == BUF_W'(b + 1));
            for (int i = 0; i < READER_SLOTS; i++) begin
                if ((CNT_W'(i) < eff_r) && (r_holds[i] == BUF_W'(b + 1)))
                    used = 1'b1;
            end
            buf_free[b] = !used && (BUF_W'(b) < nbuf);
        end
    end

    always_comb begin
        any_buf  = 1'b0;
        free_buf = '0;
        for (int b = NBUF_MAX - 1; b >= 0; b--) begin
            if (buf_free[b]) begin
                any_buf  = 1'b1;
                free_buf = BUF_W'(b);
            end
        end
    end

    always_comb begin
        any_slot  = 1'b0;
        free_slot = '0;
        for (int i = 0; i < READER_SLOTS; i++)
            slot_free[i] = !r_taken[i] && (CNT_W'(i) < eff_r);
        for (int i = READER_SLOTS - 1; i >= 0; i--) begin
            if (slot_free[i]) begin
                any_slot  = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_latest  = r_latest;
        n_pending = r_pending;
        n_holds   = r_holds;
        n_taken   = r_taken;
        n_open    = r_open;
        n_out     = '0;
        unique case (r_in.cmd)
            CMD_ACQUIRE: begin
                n_pending    = '0;
                n_out.status = STS_NO_BUFFER;
                if (any_buf) begin
                    n_pending          = free_buf + BUF_W'(1);
                    n_out.buffer_index = free_buf;
                    n_out.status       = STS_OK;
                end
            end
            CMD_PUBLISH: begin
                if (r_pending == '0) begin
                    n_out.status = STS_NO_PENDING;
                end else begin
                    n_latest = r_pending;
                    for (int i = 0; i < READER_SLOTS; i++) begin
                        if ((CNT_W'(i) < eff_r) && (r_holds[i] == '0))
                            n_holds[i] = r_pending;
                    end
                    n_out.buffer_index = r_pending - BUF_W'(1);
                    n_pending          = '0;
                end
            end
            CMD_OPEN: begin
                n_out.status = STS_NO_SLOT;
                if ((r_open < eff_r) && any_slot) begin
                    n_taken[free_slot]   = 1'b1;
                    n_open               = r_open + CNT_W'(1);
                    n_out.granted_reader = free_slot;
                    n_out.status         = STS_OK;
                end
            end
            CMD_CLOSE: begin
                if ((CNT_W'(r_in.reader_id) >= eff_r) || !r_taken[r_in.reader_id]) begin
                    n_out.status = STS_NO_SLOT;
                end else begin
                    n_taken[r_in.reader_id] = 1'b0;
                    if (r_open != '0) n_open = r_open - CNT_W'(1);
                end
            end
            CMD_FETCH: begin
                if (CNT_W'(r_in.reader_id) >= eff_r) begin
                    n_out.status = STS_NO_SLOT;
                end else begin
                    n_holds[r_in.reader_id] = r_latest;
                    n_out.buffer_index = (r_latest != '0) ? r_latest - BUF_W'(1) : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_readers <= READERS_RESET;
            r_latest  <= BUF_W'(1);
            r_pending <= '0;
            r_taken   <= '0;
            r_open    <= '0;
            r_strobe  <= 1'b0;
            for (int i = 0; i < READER_SLOTS; i++) r_holds[i] <= '0;
        end else begin
            r_strobe <= i_dp_ctrl.execute;
            if (i_cfg_we) r_readers <= i_cfg_wdata;
            if (i_dp_ctrl.execute) begin
                r_latest  <= n_latest;
                r_pending <= n_pending;
                r_taken   <= n_taken;
                r_open    <= n_open;
                r_holds   <= n_holds;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_ctrl.capture) r_in <= i_in;
        if (i_dp_ctrl.execute) r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule

/* hw/rtl/multi_reader_buffer_index_manager.sv */
// Top level of the multi-reader buffer index manager.
// Depends on mrbim_pkg, mrbim_ctrl and mrbim_dp.

// Hands out buffer indices to one writer and up to eight readers sharing
// readers+2 buffers. A command word is taken when start is high and busy is
// low; busy then stays high for one cycle while the datapath scans the ten
// buffer marks and eight reader slots, and the result word appears on o_out
// with o_strobe high for exactly one cycle right after. A new command can be
// started in the same cycle its predecessor's result is shown. Results cannot
// be held off by the receiver. The reader-count register may be written any
// time the block is not busy.
module multi_reader_buffer_index_manager (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  mrbim_pkg::t_in_word             i_in,
    input  logic                            i_cfg_we,
    input  logic [mrbim_pkg::CNT_W-1:0]     i_cfg_wdata,
    output logic                            o_strobe,
    output mrbim_pkg::t_out_word            o_out
);
    import mrbim_pkg::*;

    t_dp_ctrl dp_ctrl;

    mrbim_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .o_dp_ctrl (dp_ctrl)
    );

    mrbim_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dp_ctrl   (dp_ctrl),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_out       (o_out)
    );

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not enter execution");

    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (!busy && o_strobe))
        else $error("execution did not finish with a result strobe");

    a_strobe_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without execution");

endmodule

/* tb/tb_multi_reader_buffer_index_manager.sv */
// Testbench for multi_reader_buffer_index_manager: random and directed command words,
// with a built-in predictor of buffer and slot bookkeeping checked against every result.
// Depends on mrbim_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_multi_reader_buffer_index_manager;
    import mrbim_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int GAP_PCT     = 18;
    localparam logic [2:0] CMD_TOP = 3'd7;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_in_word            i_in;
    logic                i_cfg_we;
    logic [CNT_W-1:0]    i_cfg_wdata;
    logic                o_strobe;
    t_out_word           o_out;

    multi_reader_buffer_index_manager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_out       (o_out)
    );

    // predictor state, buffers stored one-based, 0 = none
    logic [CNT_W-1:0] slot_cfg;
    logic [BUF_W-1:0] latest_buf;
    logic [BUF_W-1:0] pending_buf;
    logic [BUF_W-1:0] held_buf [READER_SLOTS];
    logic             slot_busy [READER_SLOTS];
    int               open_cnt;

    t_in_word  cmd_words[$];
    t_out_word answers_due[$];
    bit        word_taken;
    bit        no_gaps;
    int        cycles;
    int        errors;

    function automatic int active_slots(logic [CNT_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > READER_SLOTS)
            return READER_SLOTS;
        return int'(v);
    endfunction

    function automatic t_out_word apply_command(t_in_word w);
        t_out_word          res;
        int                 r;
        int                 nbuf;
        int                 h;
        int                 rid;
        bit                 found;
        logic [NBUF_MAX-1:0] marked;
        res   = '0;
        r     = active_slots(slot_cfg);
        nbuf  = r + SPARE_BUFFERS;
        rid   = int'(w.reader_id);
        found = 1'b0;
        case (w.cmd)
            CMD_ACQUIRE: begin
                marked = '0;
                if (latest_buf != 0 && int'(latest_buf) <= nbuf)
                    marked[int'(latest_buf) - 1] = 1'b1;
                // only live slots count; stale marks past nbuf are ignored
                for (int i = 0; i < r; i++) begin
                    h = int'(held_buf[i]);
                    if (h != 0 && h <= nbuf)
                        marked[h - 1] = 1'b1;
                end
                pending_buf = '0;
                res.status  = STS_NO_BUFFER;
                for (int i = 0; i < nbuf; i++) begin
                    if (!found && !marked[i]) begin
                        found            = 1'b1;
                        pending_buf      = BUF_W'(i + 1);
                        res.buffer_index = 4'(i);
                        res.status       = STS_OK;
                    end
                end
            end
            CMD_PUBLISH: begin
                if (pending_buf == 0) begin
                    res.status = STS_NO_PENDING;
                end else begin
                    latest_buf = pending_buf;
                    for (int i = 0; i < r; i++)
                        if (held_buf[i] == 0)
                            held_buf[i] = pending_buf;
                    res.buffer_index = 4'(pending_buf - 1'b1);
                    pending_buf      = '0;
                end
            end
            CMD_OPEN: begin
                res.status = STS_NO_SLOT;
                if (open_cnt < r) begin
                    for (int i = 0; i < r; i++) begin
                        if (!found && !slot_busy[i]) begin
                            found              = 1'b1;
                            slot_busy[i]       = 1'b1;
                            open_cnt++;
                            res.granted_reader = 3'(i);
                            res.status         = STS_OK;
                        end
                    end
                end
            end
            CMD_CLOSE: begin
                if (rid >= r || !slot_busy[rid]) begin
                    res.status = STS_NO_SLOT;
                end else begin
                    // held buffer stays marked after close
                    slot_busy[rid] = 1'b0;
                    if (open_cnt > 0)
                        open_cnt--;
                end
            end
            CMD_FETCH: begin
                if (rid >= r) begin
                    res.status = STS_NO_SLOT;
                end else begin
                    held_buf[rid]    = latest_buf;
                    res.buffer_index = (latest_buf != 0) ? 4'(latest_buf - 1'b1) : 4'd0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // driver: holds a word until taken, then maybe gaps, then pulls the next
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && !word_taken)) begin
            if (cmd_words.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
                start <= 1'b1;
                i_in  <= cmd_words.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_out_word want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("multi_reader_buffer_index_manager test failed");
            $finish;
        end else if (!i_rst_n) begin
            slot_cfg    = READERS_RESET;
            latest_buf  = BUF_W'(1);
            pending_buf = '0;
            open_cnt    = 0;
            word_taken  = 1'b0;
            for (int i = 0; i < READER_SLOTS; i++) begin
                held_buf[i]  = '0;
                slot_busy[i] = 1'b0;
            end
        end else begin
            if (o_strobe) begin
                if (answers_due.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (o_out.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_out.status);
                        errors++;
                    end
                    if (o_out.buffer_index !== want.buffer_index) begin
                        $error("buffer_index: expected %0d, got %0d",
                               want.buffer_index, o_out.buffer_index);
                        errors++;
                    end
                    if (o_out.granted_reader !== want.granted_reader) begin
                        $error("granted_reader: expected %0d, got %0d",
                               want.granted_reader, o_out.granted_reader);
                        errors++;
                    end
                end
            end
            if (i_cfg_we)
                slot_cfg = i_cfg_wdata;
            word_taken = start && !busy;
            if (word_taken)
                answers_due.push_back(apply_command(i_in));
        end
    end

    task automatic push_cmd(logic [2:0] c, logic [2:0] rid);
        t_in_word w;
        w.cmd       = c;
        w.reader_id = rid;
        cmd_words.push_back(w);
    endtask

    task automatic wait_drained();
        while (cmd_words.size() != 0 || start || answers_due.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic set_readers(logic [CNT_W-1:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [CNT_W-1:0] cfg_plan [10];
        int               span;
        int               n;
        logic [2:0]       rid;
        cfg_plan = '{4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd15, 4'd9, 4'd0, 4'd4, 4'd8};
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        no_gaps     = 1'b0;
        cycles      = 0;
        errors      = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset count of eight readers
        push_cmd(CMD_FETCH, 3'd0);      // fetch on an unopened slot
        push_cmd(CMD_PUBLISH, 3'd0);    // nothing pending
        push_cmd(CMD_ACQUIRE, 3'd0);
        push_cmd(CMD_ACQUIRE, 3'd0);    // replaces the pending one
        push_cmd(CMD_PUBLISH, 3'd0);
        push_cmd(CMD_OPEN, 3'd0);
        push_cmd(CMD_CLOSE, 3'd7);      // slot not taken
        push_cmd(CMD_CLOSE, 3'd0);
        push_cmd(CMD_CLOSE, 3'd0);
        push_cmd(CMD_FETCH + 3'd1, 3'd7);
        push_cmd(3'(CMD_FETCH + 3'd2), 3'd5);
        push_cmd(CMD_TOP, 3'd7);
        push_cmd(CMD_FETCH, 3'd7);

        // zero clamps to one slot; marks past the three buffers are stale
        set_readers(4'd0);
        push_cmd(CMD_FETCH, 3'd1);      // slot out of range
        push_cmd(CMD_CLOSE, 3'd1);
        push_cmd(CMD_OPEN, 3'd0);
        push_cmd(CMD_OPEN, 3'd0);       // no slot left
        push_cmd(CMD_ACQUIRE, 3'd0);
        push_cmd(CMD_PUBLISH, 3'd0);
        push_cmd(CMD_FETCH, 3'd0);
        push_cmd(CMD_ACQUIRE, 3'd0);

        // above the maximum clamps to eight
        set_readers(4'd15);
        push_cmd(CMD_FETCH, 3'd7);
        push_cmd(CMD_OPEN, 3'd0);
        push_cmd(CMD_ACQUIRE, 3'd0);

        for (int p = 0; p < 10; p++) begin
            set_readers(cfg_plan[p]);
            span    = active_slots(cfg_plan[p]);
            no_gaps = (p == 4);
            n       = 0;
            while (n < 140) begin
                rid = ($urandom_range(1) != 0) ? 3'($urandom_range(span - 1))
                                               : 3'($urandom_range(7));
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        // the usual writer/reader round trip
                        push_cmd(CMD_ACQUIRE, 3'($urandom_range(7)));
                        push_cmd(CMD_PUBLISH, 3'($urandom_range(7)));
                        push_cmd(CMD_FETCH, rid);
                        n += 3;
                    end
                    4: begin
                        push_cmd(CMD_OPEN, 3'($urandom_range(7)));
                        n++;
                    end
                    5: begin
                        push_cmd(CMD_CLOSE, rid);
                        n++;
                    end
                    6: begin
                        push_cmd(CMD_FETCH, rid);
                        n++;
                    end
                    7: begin
                        push_cmd(CMD_ACQUIRE, rid);
                        n++;
                    end
                    8: begin
                        push_cmd(CMD_PUBLISH, rid);
                        n++;
                    end
                    default: begin
                        push_cmd(3'($urandom_range(7)), 3'($urandom_range(7)));
                        n++;
                    end
                endcase
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("multi_reader_buffer_index_manager test passed");
        else
            $display("multi_reader_buffer_index_manager test failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/mrbim_pkg.sv
hw/rtl/mrbim_ctrl.sv
hw/rtl/mrbim_dp.sv
hw/rtl/multi_reader_buffer_index_manager.sv
tb/tb_multi_reader_buffer_index_manager.sv
